// ===== rtl/core/seeded_byte_shuffle_defines.svh =====
// Assertion macros shared by the seeded byte shuffle RTL.
`ifndef SEEDED_BYTE_SHUFFLE_DEFINES_SVH
`define SEEDED_BYTE_SHUFFLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seeded_byte_shuffle: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seeded_byte_shuffle: check failed");

`endif

// ===== rtl/core/sbs_pkg.sv =====
// Types, constants and seed functions of the seeded byte shuffle.
package sbs_pkg;

  localparam int MAX_LEN     = 64;
  localparam int STORE_DEPTH = 64;
  localparam int LIMIT       = (MAX_LEN > STORE_DEPTH) ? STORE_DEPTH : MAX_LEN;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BYTE_W      = 8;
  localparam int SEED_W      = 32;
  localparam int ROT         = 5;
  localparam int STIR_SHL    = 6;
  localparam int STIR_SHR    = 2;
  localparam int IDX_SHIFT   = 16;
  localparam int DVD_W       = SEED_W - IDX_SHIFT;
  localparam int REM_STEP_W  = $clog2(DVD_W);

  localparam logic [SEED_W-1:0]     GOLDEN        = 32'h9E3779B9;
  localparam logic [CNT_W-1:0]      LIMIT_CNT     = CNT_W'(LIMIT);
  localparam logic [CNT_W-1:0]      ONE_CNT       = CNT_W'(1);
  localparam logic [IDX_W-1:0]      ONE_IDX       = IDX_W'(1);
  localparam logic [REM_STEP_W-1:0] REM_STEP_LAST = REM_STEP_W'(DVD_W - 1);
  localparam logic [REM_STEP_W-1:0] REM_STEP_ONE  = REM_STEP_W'(1);

  typedef struct packed {
    logic              sh_we;
    logic [IDX_W-1:0]  sh_waddr;
    logic [BYTE_W-1:0] sh_wdata;
    logic              sh_re;
    logic [IDX_W-1:0]  sh_raddr_a;
    logic [IDX_W-1:0]  sh_raddr_b;
    logic              cm_we;
    logic [IDX_W-1:0]  cm_waddr;
    logic [BYTE_W-1:0] cm_wdata;
    logic [IDX_W-1:0]  cm_raddr;
  } mem_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sh_rdata_a;
    logic [BYTE_W-1:0] sh_rdata_b;
    logic [BYTE_W-1:0] cm_rdata;
  } mem_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } rem_rsp_t;

  function automatic logic [SEED_W-1:0] mix_in(input logic [SEED_W-1:0] seed,
                                               input logic [BYTE_W-1:0] b);
    logic [SEED_W-1:0] prod;
    logic [SEED_W-1:0] x;
    prod = {{(SEED_W-BYTE_W){1'b0}}, b} * GOLDEN;
    x    = seed ^ prod;
    return {x[SEED_W-1-ROT:0], x[SEED_W-1:SEED_W-ROT]};
  endfunction

  function automatic logic [SEED_W-1:0] stir(input logic [SEED_W-1:0] seed,
                                             input logic [BYTE_W-1:0] c);
    return seed ^ ({{(SEED_W-BYTE_W){1'b0}}, c} + (seed << STIR_SHL) + (seed >> STIR_SHR));
  endfunction

endpackage

// ===== rtl/core/sbs_rem_unit.sv =====
// Bit-serial restoring remainder unit for the swap index.
module sbs_rem_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  sbs_pkg::rem_req_t  req,
  output sbs_pkg::rem_rsp_t  rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [sbs_pkg::REM_STEP_W-1:0] cnt_r;
  logic [sbs_pkg::CNT_W-1:0]      rem_r;
  logic [sbs_pkg::CNT_W-1:0]      rem_nxt;
  logic [sbs_pkg::DVD_W-1:0]      dvd_r;
  logic [sbs_pkg::CNT_W-1:0]      dsr_r;
  logic [sbs_pkg::CNT_W:0]        trial;
  logic [sbs_pkg::CNT_W:0]        diff;

  assign trial   = {rem_r, dvd_r[sbs_pkg::DVD_W-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[sbs_pkg::CNT_W-1:0]
                                            : trial[sbs_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + sbs_pkg::REM_STEP_ONE;
        if (cnt_r == sbs_pkg::REM_STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/sbs_mem.sv =====
// Shuffle and companion byte memories with registered read ports.
module sbs_mem (
  input  logic               clk,
  input  sbs_pkg::mem_req_t  req,
  output sbs_pkg::mem_rsp_t  rsp
);

  logic [sbs_pkg::BYTE_W-1:0] sh_mem [sbs_pkg::STORE_DEPTH];
  logic [sbs_pkg::BYTE_W-1:0] cm_mem [sbs_pkg::STORE_DEPTH];
  logic [sbs_pkg::BYTE_W-1:0] sh_rd_a_r;
  logic [sbs_pkg::BYTE_W-1:0] sh_rd_b_r;
  logic [sbs_pkg::BYTE_W-1:0] cm_rd_r;

  always_ff @(posedge clk) begin
    if (req.sh_we) begin
      sh_mem[req.sh_waddr] <= req.sh_wdata;
    end
    if (req.sh_re) begin
      sh_rd_a_r <= sh_mem[req.sh_raddr_a];
      sh_rd_b_r <= sh_mem[req.sh_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (req.cm_we) begin
      cm_mem[req.cm_waddr] <= req.cm_wdata;
    end
    cm_rd_r <= cm_mem[req.cm_raddr];
  end

  assign rsp.sh_rdata_a = sh_rd_a_r;
  assign rsp.sh_rdata_b = sh_rd_b_r;
  assign rsp.cm_rdata   = cm_rd_r;

endmodule

// ===== rtl/core/seeded_byte_shuffle.sv =====
// Seeded byte shuffle top level: load sequencer, shuffle pass and emission.
// Loading takes one request a cycle while in_ready is high; the last request starts the
// shuffle pass, or emission at once when at most one byte is held. Each shuffle step, for
// positions n-1 down to 1, uses the 16-step bit-serial remainder unit and the read, write,
// write swap on the memory. Emission gives the bytes from position 0 upward and holds while
// out_ready is low. Synchronous reset clears sequencer, count, seed and drop flag.
`include "seeded_byte_shuffle_defines.svh"

module seeded_byte_shuffle (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sbs_pkg::BYTE_W-1:0] in_box_byte,
  input  logic [sbs_pkg::BYTE_W-1:0] in_companion_byte,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sbs_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last,
  output logic                       out_overflowed
);

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_CRD  = 9'b000000010,
    S_STIR = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_RD   = 9'b000010000,
    S_WR_I = 9'b000100000,
    S_WR_J = 9'b001000000,
    S_ERD  = 9'b010000000,
    S_ECAP = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [sbs_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [sbs_pkg::IDX_W-1:0]   j_r, j_nxt;
  logic [sbs_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [sbs_pkg::CNT_W-1:0]   fill_m1;
  logic [sbs_pkg::SEED_W-1:0]  seed_r, seed_nxt;
  logic [sbs_pkg::SEED_W-1:0]  stirred;
  logic                        drop_r, drop_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [sbs_pkg::BYTE_W-1:0]  out_byte_r;
  logic                        out_last_r;
  logic                        out_ovf_r;
  logic                        out_load;
  logic                        in_fire;
  logic                        store_ok;
  logic                        emit_last;

  sbs_pkg::mem_req_t mreq;
  sbs_pkg::mem_rsp_t mrsp;
  sbs_pkg::rem_req_t rreq;
  sbs_pkg::rem_rsp_t rrsp;

  sbs_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  sbs_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .rsp   (rrsp)
  );

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign store_ok  = (fill_r < sbs_pkg::LIMIT_CNT);
  assign stirred   = sbs_pkg::stir(seed_r, mrsp.cm_rdata);
  assign emit_last = ({1'b0, idx_r} == (fill_r - sbs_pkg::ONE_CNT));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    fill_nxt  = fill_r;
    fill_m1   = '0;
    seed_nxt  = seed_r;
    drop_nxt  = drop_r;
    out_load  = 1'b0;
    mreq      = '0;
    rreq      = '0;
    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (store_ok) begin
            mreq.sh_we    = 1'b1;
            mreq.sh_waddr = fill_r[sbs_pkg::IDX_W-1:0];
            mreq.sh_wdata = in_box_byte;
            mreq.cm_we    = 1'b1;
            mreq.cm_waddr = fill_r[sbs_pkg::IDX_W-1:0];
            mreq.cm_wdata = in_companion_byte;
            fill_nxt      = fill_r + sbs_pkg::ONE_CNT;
            seed_nxt      = sbs_pkg::mix_in(seed_r, in_box_byte);
          end else begin
            drop_nxt = 1'b1;
          end
          fill_m1 = fill_nxt - sbs_pkg::ONE_CNT;
          if (in_last_byte) begin
            if (fill_nxt > sbs_pkg::ONE_CNT) begin
              idx_nxt   = fill_m1[sbs_pkg::IDX_W-1:0];
              state_nxt = S_CRD;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_CRD: begin
        mreq.cm_raddr = idx_r;
        state_nxt     = S_STIR;
      end
      S_STIR: begin
        seed_nxt      = stirred;
        rreq.start    = 1'b1;
        rreq.dividend = stirred[sbs_pkg::SEED_W-1:sbs_pkg::IDX_SHIFT];
        rreq.divisor  = {1'b0, idx_r} + sbs_pkg::ONE_CNT;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (rrsp.done) begin
          j_nxt     = rrsp.rem[sbs_pkg::IDX_W-1:0];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mreq.sh_re      = 1'b1;
        mreq.sh_raddr_a = idx_r;
        mreq.sh_raddr_b = j_r;
        state_nxt       = S_WR_I;
      end
      S_WR_I: begin
        mreq.sh_we    = 1'b1;
        mreq.sh_waddr = idx_r;
        mreq.sh_wdata = mrsp.sh_rdata_b;
        seed_nxt      = seed_r
                        + {{(sbs_pkg::SEED_W-sbs_pkg::BYTE_W){1'b0}}, mrsp.sh_rdata_b};
        state_nxt     = S_WR_J;
      end
      S_WR_J: begin
        mreq.sh_we    = 1'b1;
        mreq.sh_waddr = j_r;
        mreq.sh_wdata = mrsp.sh_rdata_a;
        if (idx_r == sbs_pkg::ONE_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end else begin
          idx_nxt   = idx_r - sbs_pkg::ONE_IDX;
          state_nxt = S_CRD;
        end
      end
      S_ERD: begin
        mreq.sh_re      = 1'b1;
        mreq.sh_raddr_a = idx_r;
        state_nxt       = S_ECAP;
      end
      S_ECAP: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (emit_last) begin
            fill_nxt  = '0;
            seed_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + sbs_pkg::ONE_IDX;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      idx_r       <= '0;
      j_r         <= '0;
      fill_r      <= '0;
      seed_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      fill_r      <= fill_nxt;
      seed_r      <= seed_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= mrsp.sh_rdata_a;
      out_last_r <= emit_last;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

  `SBS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= sbs_pkg::LIMIT_CNT)
  `SBS_ASSERT_IMPL(a_swap_range, state_r == S_WR_I, j_r <= idx_r)
  `SBS_ASSERT_IMPL(a_rem_in_div, rrsp.done, state_r == S_DIV)
  `SBS_ASSERT_NEXT(a_block_clear, out_load && emit_last, (fill_r == '0) && !drop_r && out_valid_r)

endmodule
